/* design/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

  localparam int IDX_W  = 13;
  localparam int FREE_W = 14;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_WRITE   = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_FETCH,
    ST_MODIFY,
    ST_SCAN,
    ST_PICK,
    ST_COMMIT,
    ST_FAIL
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [IDX_W-1:0]   block_index;
    logic               bit_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   result_index;
    logic               read_value;
    logic               status;
    logic [FREE_W-1:0]  free_left;
  } rsp_t;

endpackage

/* design/bba_if.sv */
// Request and response channel interfaces of the bitmap block allocator.
interface bba_req_if;
  logic           valid;
  logic           ready;
  bba_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bba_rsp_if;
  logic           valid;
  logic           ready;
  bba_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/bba_mem.sv */
// Bitmap word memory: one write port, one read port with registered data.
module bba_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bitmap_block_allocator.sv */
// Bitmap block allocator: first-fit allocate, release, write and read of block bits.
// Release, write and read pass through SPLIT, FETCH and MODIFY after accept; MODIFY holds
// until the result register is free. Allocate scans from word 0 to the first non-full
// bitmap word, then passes PICK and COMMIT; the scan reads one word per cycle through the single memory read port.
// One item is in flight at a time; the result register frees the output side.
// After reset a clearing pass zeroes each of the MAP_WORDS bitmap words before accepting.
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = 8192,
  parameter int WORD_BITS  = 32
) (
  input logic         clk_i,
  input logic         rst_ni,
  bba_req_if.sink     req_i,
  bba_rsp_if.source   rsp_o
);

  localparam int IDX_W     = bba_pkg::IDX_W;
  localparam int FREE_W    = bba_pkg::FREE_W;
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SW        = $clog2(MAP_WORDS + 1);
  localparam int BITW      = $clog2(WORD_BITS);
  localparam int CW        = $clog2(NUM_BLOCKS + 1);
  localparam int BLKW      = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int RNGW      = (CW > IDX_W) ? CW : IDX_W;
  localparam int BCW       = (BLKW > CW) ? BLKW : CW;
  localparam int RCP_SH    = 20;
  localparam int RCP_W     = 18;
  localparam int RCP       = (1 << RCP_SH) / WORD_BITS;
  localparam int PRW       = IDX_W + RCP_W;
  localparam int QW        = PRW - RCP_SH;

  bba_pkg::state_e          state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  bba_pkg::req_t            item_q, item_d;
  logic [QW-1:0]            q0_q, q0_d;
  logic [QW-1:0]            word_q, word_d;
  logic [BITW-1:0]          bit_q, bit_d;
  logic [SW-1:0]            scan_q, scan_d;
  logic                     pend_q, pend_d;
  logic [AW-1:0]            chk_q, chk_d;
  logic [AW-1:0]            hitw_q, hitw_d;
  logic [WORD_BITS-1:0]     wdat_q, wdat_d;
  logic [BLKW-1:0]          blk_q, blk_d;
  bba_pkg::rsp_t            rsp_q, rsp_d;
  logic                     rvld_q, rvld_d;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]     mem_wdata, mem_rdata;

  logic [PRW-1:0]           prod;
  logic [IDX_W-1:0]         rem_full;
  logic                     bump;
  logic                     in_range;
  logic [BITW-1:0]          zero_pos;
  logic [WORD_BITS-1:0]     sel_mask;
  logic                     slot_free;
  logic                     issue;
  logic                     hit;
  logic                     emit;

  bba_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // block / WORD_BITS by reciprocal; estimate is low by at most one
  assign prod     = PRW'(req_i.data.block_index) * PRW'(RCP);
  assign rem_full = item_q.block_index - IDX_W'(32'(q0_q) * 32'(WORD_BITS));
  assign bump     = (rem_full >= IDX_W'(WORD_BITS));
  assign in_range = (RNGW'(item_q.block_index) < RNGW'(NUM_BLOCKS));
  assign sel_mask = WORD_BITS'(1) << bit_q;
  assign slot_free = !rvld_q || rsp_o.ready;
  assign issue    = (state_q == bba_pkg::ST_SCAN) && (scan_q != SW'(MAP_WORDS));
  assign hit      = pend_q && (mem_rdata != '1);

  always_comb begin
    zero_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!wdat_q[i]) begin
        zero_pos = BITW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= CW'(NUM_BLOCKS);
      pend_q  <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    q0_q   <= q0_d;
    word_q <= word_d;
    bit_q  <= bit_d;
    scan_q <= scan_d;
    chk_q  <= chk_d;
    hitw_q <= hitw_d;
    wdat_q <= wdat_d;
    blk_q  <= blk_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    item_d    = item_q;
    q0_d      = q0_q;
    word_d    = word_q;
    bit_d     = bit_q;
    scan_d    = scan_q;
    pend_d    = 1'b0;
    chk_d     = chk_q;
    hitw_d    = hitw_q;
    wdat_d    = wdat_q;
    blk_d     = blk_q;
    rsp_d     = rsp_q;
    emit      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(word_q);
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    req_i.ready = 1'b0;

    case (state_q)
      bba_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          item_d = req_i.data;
          q0_d   = prod[PRW-1:RCP_SH];
          if (req_i.data.action == bba_pkg::ACT_ALLOC) begin
            if (cnt_q == '0) begin
              state_d = bba_pkg::ST_FAIL;
            end else begin
              scan_d  = '0;
              state_d = bba_pkg::ST_SCAN;
            end
          end else begin
            state_d = bba_pkg::ST_SPLIT;
          end
        end
      end
      bba_pkg::ST_SPLIT: begin
        word_d  = q0_q + QW'(bump);
        bit_d   = bump ? BITW'(rem_full - IDX_W'(WORD_BITS)) : BITW'(rem_full);
        state_d = bba_pkg::ST_FETCH;
      end
      bba_pkg::ST_FETCH: begin
        mem_re    = 1'b1;
        mem_raddr = in_range ? AW'(word_q) : '0;
        state_d   = bba_pkg::ST_MODIFY;
      end
      bba_pkg::ST_MODIFY: begin
        if (slot_free) begin
          emit = 1'b1;
          rsp_d.result_index = item_q.block_index;
          rsp_d.status       = bba_pkg::STATUS_OK;
          rsp_d.read_value   = 1'b0;
          case (item_q.action)
            bba_pkg::ACT_RELEASE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata & ~sel_mask;
                if (cnt_q < CW'(NUM_BLOCKS)) begin
                  cnt_d = cnt_q + 1'b1;
                end
              end
            end
            bba_pkg::ACT_WRITE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_wdata = item_q.bit_value ? (mem_rdata | sel_mask)
                                             : (mem_rdata & ~sel_mask);
              end
            end
            bba_pkg::ACT_READ: begin
              rsp_d.read_value = in_range && mem_rdata[bit_q];
            end
            default: begin
            end
          endcase
          rsp_d.free_left = FREE_W'(cnt_d);
          state_d = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = scan_q[AW-1:0];
          scan_d    = scan_q + 1'b1;
          chk_d     = scan_q[AW-1:0];
          pend_d    = 1'b1;
        end
        if (hit) begin
          hitw_d  = chk_q;
          wdat_d  = mem_rdata;
          pend_d  = 1'b0;
          state_d = bba_pkg::ST_PICK;
        end else if (pend_q && !issue) begin
          state_d = bba_pkg::ST_FAIL;
        end
      end
      bba_pkg::ST_PICK: begin
        blk_d   = BLKW'(hitw_q) * BLKW'(WORD_BITS) + BLKW'(zero_pos);
        bit_d   = zero_pos;
        state_d = bba_pkg::ST_COMMIT;
      end
      bba_pkg::ST_COMMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          rsp_d.read_value = 1'b0;
          if (BCW'(blk_q) < BCW'(NUM_BLOCKS)) begin
            mem_we    = 1'b1;
            mem_waddr = hitw_q;
            mem_wdata = wdat_q | sel_mask;
            cnt_d     = cnt_q - 1'b1;
            rsp_d.result_index = IDX_W'(blk_q);
            rsp_d.status       = bba_pkg::STATUS_OK;
          end else begin
            rsp_d.result_index = item_q.block_index;
            rsp_d.status       = bba_pkg::STATUS_NO_SPACE;
          end
          rsp_d.free_left = FREE_W'(cnt_d);
          state_d = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_FAIL: begin
        if (slot_free) begin
          emit = 1'b1;
          rsp_d.result_index = item_q.block_index;
          rsp_d.read_value   = 1'b0;
          rsp_d.status       = bba_pkg::STATUS_NO_SPACE;
          rsp_d.free_left    = FREE_W'(cnt_q);
          state_d = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      rvld_d = 1'b1;
    end else if (rsp_o.ready) begin
      rvld_d = 1'b0;
    end else begin
      rvld_d = rvld_q;
    end
  end

  assign rsp_o.valid = rvld_q;
  assign rsp_o.data  = rsp_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NUM_BLOCKS))
    else $error("free count above block total");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("bitmap read and write in the same cycle");

  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_COMMIT && emit && rsp_d.status == bba_pkg::STATUS_OK)
    |=> cnt_q == CW'($past(cnt_q) - 1'b1))
    else $error("successful allocate did not decrement free count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> state_q != bba_pkg::ST_IDLE)
    else $error("accepted beat did not start work");
`endif

endmodule
